// ===== sv/on_off_toggler_with_lifetime_top_defines.svh =====
// Assertion helpers shared by the toggler's RTL files.
`ifndef ON_OFF_TOGGLER_WITH_LIFETIME_TOP_DEFINES_SVH
`define ON_OFF_TOGGLER_WITH_LIFETIME_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OTL_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("otl assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define OTL_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("otl assertion failed");

`endif

// ===== sv/otl_pkg.sv =====
package otl_pkg;

	localparam int TIME_BITS  = 48;
	localparam int NOW_W      = 48;
	localparam int DELAY_W    = 32;
	localparam int LIFE_W     = 48;
	localparam int PHASE_W    = 42;
	localparam int PER_W      = PHASE_W + 1;
	localparam int DUS_W      = 42;
	localparam int US_PER_MS  = 1000;
	localparam int FUNC_W     = 2;
	localparam int S_TDATA_W  = 80;
	localparam int M_TDATA_W  = 8;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 48;
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
	localparam int SUM_W      = 65;

	typedef logic [TIME_BITS-1:0] time_t;

	localparam time_t TIME_MAX = '1;

	localparam logic [CFG_ADDR_W-1:0] REG_LIFETIME = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ON_TIME  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_OFF_TIME = 2'd2;

	typedef enum logic [FUNC_W-1:0] {
		OP_CHECK    = 2'd0,
		OP_ACTIVATE = 2'd1,
		OP_EXPIRE   = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		time_t            now;
		logic [DUS_W-1:0] delay_us;
	} req_t;

	typedef struct packed {
		logic [LIFE_W-1:0]  lifetime;
		logic [PHASE_W-1:0] on_time;
		logic [PHASE_W-1:0] off_time;
	} cfg_t;

	// base + inc, clamped to the top of the time range
	function automatic time_t sat_add(time_t base, logic [63:0] inc);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(inc);
		if (sum > SUM_W'(TIME_MAX)) begin
			return TIME_MAX;
		end
		return sum[TIME_BITS-1:0];
	endfunction

endpackage

// ===== sv/otl_front.sv =====
module otl_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [otl_pkg::S_TDATA_W-1:0] s_tdata,  // [47:0] now_us, [79:48] delay_ms
	input  logic [otl_pkg::FUNC_W-1:0]    s_tuser,  // [1:0] func
	input  logic                          q_full,
	output logic                          q_push,
	output otl_pkg::req_t                 q_data
);

	logic          valid_s1;
	otl_pkg::req_t req_s1;
	logic          take;

	assign s_tready = !valid_s1 || !q_full;
	assign take     = s_tvalid && s_tready;
	assign q_push   = valid_s1 && !q_full;
	assign q_data   = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// decode and scale ms to us up front so the back end sees microseconds only
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1.op       <= otl_pkg::op_t'(s_tuser);
			req_s1.now      <= otl_pkg::TIME_BITS'(s_tdata[otl_pkg::NOW_W-1:0]);
			req_s1.delay_us <=
				otl_pkg::DUS_W'(s_tdata[otl_pkg::NOW_W +: otl_pkg::DELAY_W]) *
				otl_pkg::DUS_W'(otl_pkg::US_PER_MS);
		end
	end

endmodule

// ===== sv/otl_queue.sv =====
`include "on_off_toggler_with_lifetime_top_defines.svh"

module otl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  otl_pkg::req_t push_data,
	output logic          full,
	input  logic          pop,
	output otl_pkg::req_t pop_data,
	output logic          empty
);

	otl_pkg::req_t                 mem_q [otl_pkg::Q_DEPTH];
	logic [otl_pkg::Q_PTR_W-1:0]   wr_q;
	logic [otl_pkg::Q_PTR_W-1:0]   rd_q;
	logic [otl_pkg::Q_CNT_W-1:0]   cnt_q;

	assign full     = cnt_q == otl_pkg::Q_CNT_W'(otl_pkg::Q_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	`OTL_ASSERT_IMP(a_no_overflow, push, !full)
	`OTL_ASSERT_IMP(a_no_underflow, pop, !empty)
	`OTL_ASSERT_NXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule

// ===== sv/otl_back.sv =====
`include "on_off_toggler_with_lifetime_top_defines.svh"

module otl_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  otl_pkg::cfg_t                 cfg,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  otl_pkg::req_t                 q_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [otl_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int REM_W = otl_pkg::PER_W + 1;
	localparam int CNT_W = $clog2(otl_pkg::TIME_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_FIN,
		S_SAT,
		S_RES
	} state_t;

	typedef enum logic [1:0] {
		ST_ACTIVE  = 2'd0,
		ST_PENDING = 2'd1,
		ST_EXPIRED = 2'd2
	} status_t;

	state_t                        state_q;
	otl_pkg::req_t                 req_q;
	status_t                       status_q;
	logic                          out_on_q;
	logic                          tog_q;
	otl_pkg::time_t                start_q;
	otl_pkg::time_t                next_q;
	otl_pkg::time_t                dvd_q;
	otl_pkg::time_t                base_q;
	logic [REM_W-1:0]              rem_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          lt_q;
	logic                          m_tvalid_q;
	logic [otl_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic [otl_pkg::PER_W-1:0]   period;
	logic [otl_pkg::PHASE_W-1:0] first;
	logic                        never;
	logic                        ran_out;
	logic                        due;
	logic                        catch_up;
	otl_pkg::time_t              since_start;
	otl_pkg::time_t              arm_time;
	logic [REM_W-1:0]            rem_sh;
	logic                        rem_ge;

	assign period      = otl_pkg::PER_W'(cfg.on_time) + otl_pkg::PER_W'(cfg.off_time);
	assign first       = out_on_q ? cfg.on_time : cfg.off_time;
	assign never       = cfg.lifetime[otl_pkg::LIFE_W-1];
	assign since_start = req_q.now - start_q;
	assign ran_out     = !never && (req_q.now > start_q) &&
		(64'(since_start) > 64'(cfg.lifetime));
	assign due         = req_q.now >= next_q;
	// due check on a live timer with a nonzero period needs the remainder loop
	assign catch_up    = (req_q.op == otl_pkg::OP_CHECK) && (status_q == ST_ACTIVE) &&
		!ran_out && due && (period != '0);
	assign arm_time    = otl_pkg::sat_add(req_q.now, 64'(req_q.delay_us));
	assign rem_sh      = {rem_q[otl_pkg::PER_W-1:0], dvd_q[otl_pkg::TIME_BITS-1]};
	assign rem_ge      = rem_sh >= REM_W'(period);

	assign q_pop    = (state_q == S_IDLE) && !q_empty && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_q      <= '0;
			status_q   <= ST_EXPIRED;
			out_on_q   <= 1'b0;
			tog_q      <= 1'b0;
			start_q    <= '0;
			next_q     <= '0;
			dvd_q      <= '0;
			base_q     <= '0;
			rem_q      <= '0;
			cnt_q      <= '0;
			lt_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						req_q   <= q_data;
						tog_q   <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= catch_up ? S_DIV : S_RES;
					case (req_q.op)
						otl_pkg::OP_ACTIVATE: begin
							if (cfg.lifetime != '0) begin
								status_q <= ST_ACTIVE;
								start_q  <= arm_time;
								next_q   <= arm_time;
							end
						end
						otl_pkg::OP_EXPIRE: begin
							if (status_q == ST_ACTIVE) begin
								status_q <= ST_PENDING;
							end
						end
						otl_pkg::OP_CHECK: begin
							// a check while expired changes nothing
							if (status_q != ST_EXPIRED) begin
								if (ran_out || status_q == ST_PENDING) begin
									tog_q    <= out_on_q;
									out_on_q <= 1'b0;
									status_q <= ST_EXPIRED;
								end else if (due) begin
									out_on_q <= !out_on_q;
									if (period == '0) begin
										tog_q <= 1'b1;
									end else begin
										dvd_q <= req_q.now - next_q;
										rem_q <= '0;
										cnt_q <= CNT_W'(otl_pkg::TIME_BITS - 1);
									end
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_DIV: begin
					// restoring remainder, one dividend bit per cycle
					rem_q <= rem_ge ? rem_sh - REM_W'(period) : rem_sh;
					dvd_q <= dvd_q << 1;
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIN: begin
					// start of the current period = now - (elapsed mod period)
					lt_q    <= rem_q < REM_W'(first);
					base_q  <= req_q.now - otl_pkg::TIME_BITS'(rem_q);
					state_q <= S_SAT;
				end
				S_SAT: begin
					if (lt_q) begin
						next_q <= otl_pkg::sat_add(base_q, 64'(first));
					end else begin
						out_on_q <= !out_on_q;
						next_q   <= otl_pkg::sat_add(base_q, 64'(period));
					end
					tog_q   <= 1'b1;
					state_q <= S_RES;
				end
				S_RES: begin
					m_tvalid_q <= 1'b1;
					m_tdata_q  <= otl_pkg::M_TDATA_W'({status_q == ST_ACTIVE, out_on_q, tog_q});
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`OTL_ASSERT_IMP(a_div_period, state_q == S_DIV, period != '0)
	`OTL_ASSERT_IMP(a_rem_range, state_q == S_FIN, rem_q < REM_W'(period))
	`OTL_ASSERT_IMP(a_out_free, state_q == S_RES, !m_tvalid_q)
	`OTL_ASSERT_NXT(a_res_shown, state_q == S_RES, m_tvalid_q)

endmodule

// ===== sv/on_off_toggler_with_lifetime_top.sv =====
// A request is registered in the front stage, queued, then popped by the back end, which runs
// S_EXEC and S_RES; a check that catches up over missed phases adds S_DIV, S_FIN and S_SAT,
// the bit-serial remainder unit being the slow step. The back end takes one item at a time
// and pops only in S_IDLE. Front and queue keep accepting until both are full.
// Reset: arst_n asynchronous, active low; output off, timer expired, times zero,
// lifetime -1 (never expires), on and off times zero.
module on_off_toggler_with_lifetime_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [otl_pkg::S_TDATA_W-1:0]  s_tdata,   // [47:0] now_us, [79:48] delay_ms
	input  logic [otl_pkg::FUNC_W-1:0]     s_tuser,   // [1:0] func
	// result channel
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [otl_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] toggled, [1] output_on,
	                                                  // [2] active, [7:3] zero
	// register writes
	input  logic                           cfg_we,
	input  logic [otl_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [otl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	otl_pkg::cfg_t cfg_q;
	logic          q_full;
	logic          q_push;
	otl_pkg::req_t q_wdata;
	logic          q_empty;
	logic          q_pop;
	otl_pkg::req_t q_rdata;

	// Register file. Writes must come only while the block is idle (the user's duty; the block does
	// not enforce it), so the back end may read these straight through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lifetime <= '1;
			cfg_q.on_time  <= '0;
			cfg_q.off_time <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				otl_pkg::REG_LIFETIME: cfg_q.lifetime <= cfg_wdata[otl_pkg::LIFE_W-1:0];
				otl_pkg::REG_ON_TIME:  cfg_q.on_time  <= cfg_wdata[otl_pkg::PHASE_W-1:0];
				otl_pkg::REG_OFF_TIME: cfg_q.off_time <= cfg_wdata[otl_pkg::PHASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: takes requests, decodes the kind and scales the delay to microseconds.
	otl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	// Short queue so the front keeps taking requests during a long catch-up.
	otl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// Back: timer state, lifetime check, phase catch-up and the result register.
	otl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_data   (q_rdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== verif/toggler_report_checker.sv =====
module toggler_report_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [otl_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [otl_pkg::FUNC_W-1:0]     s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [otl_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                           cfg_we,
	input  logic [otl_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [otl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                             fail_count,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import otl_pkg::*;

	typedef enum logic [1:0] {
		RUN_ACTIVE  = 2'd0,
		RUN_PENDING = 2'd1,
		RUN_EXPIRED = 2'd2
	} run_state_t;

	typedef struct packed {
		logic toggled;
		logic output_on;
		logic active;
	} lamp_report_t;

	localparam logic [63:0] TIME_TOP = 64'(TIME_MAX);

	// mirrored registers and timer state
	logic [LIFE_W-1:0]  life_reg;
	logic [PHASE_W-1:0] on_reg;
	logic [PHASE_W-1:0] off_reg;
	logic               lamp_on;
	run_state_t         run_st;
	logic [63:0]        start_us;
	logic [63:0]        next_us;

	lamp_report_t expected_reports[$];
	int           mismatches;

	assign fail_count = mismatches;

	function automatic logic [63:0] clamp_add(logic [63:0] base, logic [63:0] inc);
		if (inc > TIME_TOP - base) begin
			return TIME_TOP;
		end
		return base + inc;
	endfunction

	// flip, then jump over every whole on+off period missed since the due time
	function automatic void skip_phases(logic [63:0] now64);
		logic [63:0] first;
		logic [63:0] span;
		logic [63:0] d;
		logic [63:0] k;
		logic [63:0] r;
		logic [63:0] base;
		lamp_on = !lamp_on;
		first = lamp_on ? 64'(on_reg) : 64'(off_reg);
		span = 64'(on_reg) + 64'(off_reg);
		if (span == 0) begin
			return;
		end
		d = now64 - next_us;
		k = d / span;
		r = d - k * span;
		base = next_us + k * span;
		if (r < first) begin
			next_us = clamp_add(base, first);
		end else begin
			lamp_on = !lamp_on;
			next_us = clamp_add(base, span);
		end
	endfunction

	function automatic logic check_timer(logic [TIME_BITS-1:0] now);
		logic [63:0] now64;
		logic        ran_out;
		logic        was_on;
		now64 = 64'(now);
		if (run_st == RUN_EXPIRED) begin
			return 1'b0;
		end
		ran_out = !life_reg[LIFE_W-1] && now64 > start_us
			&& (now64 - start_us) > 64'(life_reg);
		if (ran_out || run_st == RUN_PENDING) begin
			was_on = lamp_on;
			run_st = RUN_EXPIRED;
			lamp_on = 1'b0;
			return was_on;
		end
		if (now64 < next_us) begin
			return 1'b0;
		end
		skip_phases(now64);
		return 1'b1;
	endfunction

	function automatic lamp_report_t step_toggler(op_t op, logic [TIME_BITS-1:0] now,
			logic [DELAY_W-1:0] delay_ms);
		lamp_report_t rep;
		logic         flip;
		flip = 1'b0;
		case (op)
			OP_CHECK: begin
				flip = check_timer(now);
			end
			OP_ACTIVATE: begin
				if (life_reg != '0) begin
					run_st = RUN_ACTIVE;
					start_us = clamp_add(64'(now), 64'(delay_ms) * 64'(US_PER_MS));
					next_us = start_us;
				end
			end
			OP_EXPIRE: begin
				if (run_st == RUN_ACTIVE) begin
					run_st = RUN_PENDING;
				end
			end
			default: begin
			end
		endcase
		rep.toggled = flip;
		rep.output_on = lamp_on;
		rep.active = (run_st == RUN_ACTIVE);
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_reg = '1;
			on_reg = '0;
			off_reg = '0;
			lamp_on = 1'b0;
			run_st = RUN_EXPIRED;
			start_us = '0;
			next_us = '0;
			mismatches = 0;
			expected_reports.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_LIFETIME: life_reg = cfg_wdata[LIFE_W-1:0];
					REG_ON_TIME:  on_reg = cfg_wdata[PHASE_W-1:0];
					REG_OFF_TIME: off_reg = cfg_wdata[PHASE_W-1:0];
					default: begin
					end
				endcase
			end
			// results first, so a stray result never pairs with a same-edge request
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					$error("unexpected result: tdata %0h", m_tdata);
					mismatches++;
				end else begin
					lamp_report_t exp_rep;
					exp_rep = expected_reports.pop_front();
					if (m_tdata[0] !== exp_rep.toggled) begin
						$error("toggled: expected %0d, got %0d", exp_rep.toggled, m_tdata[0]);
						mismatches++;
					end
					if (m_tdata[1] !== exp_rep.output_on) begin
						$error("output_on: expected %0d, got %0d", exp_rep.output_on, m_tdata[1]);
						mismatches++;
					end
					if (m_tdata[2] !== exp_rep.active) begin
						$error("active: expected %0d, got %0d", exp_rep.active, m_tdata[2]);
						mismatches++;
					end
					if (m_tdata[M_TDATA_W-1:3] !== '0) begin
						$error("pad: expected 0, got %0h", m_tdata[M_TDATA_W-1:3]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_reports.push_back(step_toggler(op_t'(s_tuser),
					s_tdata[TIME_BITS-1:0], s_tdata[TIME_BITS +: DELAY_W]));
			end
			outstanding <= expected_reports.size();
		end
	end

endmodule

// ===== verif/on_off_toggler_with_lifetime_top_test.sv =====
module on_off_toggler_with_lifetime_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import otl_pkg::*;

	localparam logic [PHASE_W-1:0] PHASE_MAX  = 42'd4294967295000;
	localparam logic [LIFE_W-1:0]  LIFE_NEVER = '1;
	localparam logic [LIFE_W-1:0]  LIFE_MAX   = 48'h7FFF_FFFF_FFFF;
	localparam int                 PHASES         = 8;
	localparam int                 REQS_PER_PHASE = 110;
	// slowest item is a catch-up check
	localparam int                 SETTLE_CYCLES  = 60;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [FUNC_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fail_count;
	int outstanding;

	// current on/off lengths, used to scale how far time moves between checks
	logic [PHASE_W-1:0] cur_on;
	logic [PHASE_W-1:0] cur_off;
	int                 burst_left;
	int                 sent_count;

	on_off_toggler_with_lifetime_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	toggler_report_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#8ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Offer one request and hold it until accepted. Requests go out in bursts;
	// between bursts tvalid drops for a random gap (zero gap = back to back).
	// Called at a rising edge, returns at the edge that accepted the request.
	task automatic send_req(input op_t op, input logic [63:0] now, input logic [31:0] delay_ms);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {delay_ms, now[TIME_BITS-1:0]};
		sent_count++;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering, wait for every result, then let a catch-up check finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// cfg_we stays high across back-to-back writes; set_config lowers it once
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [LIFE_W-1:0] life, input logic [PHASE_W-1:0] on_us,
			input logic [PHASE_W-1:0] off_us);
		write_reg(REG_LIFETIME, life);
		write_reg(REG_ON_TIME, CFG_DATA_W'(on_us));
		write_reg(REG_OFF_TIME, CFG_DATA_W'(off_us));
		cfg_we <= 1'b0;
		cur_on = on_us;
		cur_off = off_us;
	endtask

	// One random phase: a register setting, then a timeline of requests. Most
	// requests are checks at a clock that moves forward by steps sized to the
	// on+off period, so the catch-up path sees both short and long skips.
	// Sprinkled in: re-activations, expires, unknown requests and checks at
	// random times (time going backwards, wrap past the top of the range).
	task automatic run_phase(input int phase);
		logic [63:0] clock_us;
		logic [63:0] span;
		logic [63:0] step;
		int          roll;
		case (phase)
			0: set_config(LIFE_NEVER, PHASE_W'($urandom_range(1, 400)),
				PHASE_W'($urandom_range(1, 400)));
			1: set_config(LIFE_W'($urandom_range(1, 5000)), PHASE_W'($urandom_range(1, 400)),
				PHASE_W'($urandom_range(1, 400)));
			2: set_config('0, PHASE_W'($urandom_range(1, 400)),
				PHASE_W'($urandom_range(1, 400)));
			3: set_config(LIFE_MAX, '0, '0);
			4: set_config(LIFE_W'(rand64()), PHASE_MAX, PHASE_MAX);
			5: set_config(LIFE_W'($urandom_range(1, 100000)), '0,
				PHASE_W'($urandom_range(1, 400)));
			6: set_config(LIFE_NEVER, PHASE_W'($urandom_range(1, 400)), '0);
			default: set_config(LIFE_W'(rand64()), PHASE_W'(rand64() % (64'(PHASE_MAX) + 1)),
				PHASE_W'(rand64() % (64'(PHASE_MAX) + 1)));
		endcase
		span = 64'(cur_on) + 64'(cur_off);
		if (span == 0) begin
			span = 64'd1000;
		end
		// every third phase starts close to the top of the time range
		if (phase % 3 == 2) begin
			clock_us = 64'(TIME_MAX) - rand64() % (4 * span);
		end else begin
			clock_us = rand64() & 64'(TIME_MAX);
		end
		send_req(OP_ACTIVATE, clock_us, $urandom_range(0, 3));
		repeat (REQS_PER_PHASE - 1) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				send_req(OP_ACTIVATE, clock_us,
					($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5));
			end else if (roll < 11) begin
				send_req(OP_EXPIRE, clock_us, $urandom);
			end else if (roll < 13) begin
				send_req(OP_NONE, rand64(), $urandom);
			end else if (roll < 17) begin
				send_req(OP_CHECK, rand64(), $urandom);
			end else begin
				case ($urandom_range(0, 9))
					0:       step = '0;
					7, 8:    step = rand64() % (8 * span + 1);
					9:       step = rand64() % (64'd1 << 40);
					default: step = rand64() % (span + 1);
				endcase
				clock_us = (clock_us + step) & 64'(TIME_MAX);
				send_req(OP_CHECK, clock_us, $urandom);
			end
		end
		drain();
	endtask

	// Result side: segments of always-ready, light, medium and heavy stalls.
	// Once, some way into the random part, it refuses results for a long
	// stretch while the sender keeps offering, so the block backs up.
	initial begin : result_sink
		int seg_len;
		int mode;
		bit held;
		held = 1'b0;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && sent_count >= 300) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				seg_len = $urandom_range(4, 60);
				mode = $urandom_range(0, 3);
				repeat (seg_len) begin
					case (mode)
						0:       m_tready <= 1'b1;
						1:       m_tready <= ($urandom_range(0, 3) != 0);
						2:       m_tready <= 1'($urandom_range(0, 1));
						default: m_tready <= ($urandom_range(0, 4) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_CHECK;
		cfg_we <= 1'b0;
		cfg_addr <= REG_LIFETIME;
		cfg_wdata <= '0;
		cur_on = '0;
		cur_off = '0;
		burst_left = 0;
		sent_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset settings: never expires, on and off both zero
		send_req(OP_CHECK, 64'd0, '0);                       // check while expired
		send_req(OP_EXPIRE, 64'(TIME_MAX), '0);              // expire while not active
		send_req(OP_NONE, 64'(TIME_MAX), '1);                // unknown request
		send_req(OP_ACTIVATE, 64'(TIME_MAX) - 5, '1);        // start saturates at the top
		send_req(OP_CHECK, 64'd0, '0);                       // not due yet
		send_req(OP_CHECK, 64'(TIME_MAX), '0);               // zero period: one flip
		send_req(OP_CHECK, 64'(TIME_MAX), '0);               // and another
		drain();

		// short lifetime, short phases
		set_config(48'd1000, 42'd100, 42'd200);
		send_req(OP_ACTIVATE, 64'd5000, 32'd1);              // start at 6000
		send_req(OP_CHECK, 64'd5999, '0);                    // before the start
		send_req(OP_CHECK, 64'd6000, '0);                    // first due toggle
		send_req(OP_CHECK, 64'd6450, '0);                    // skip a whole period
		send_req(OP_EXPIRE, 64'd6500, '0);                   // now pending
		send_req(OP_ACTIVATE, 64'd6500, '0);                 // re-arm from pending
		send_req(OP_EXPIRE, 64'd6550, '0);
		send_req(OP_CHECK, 64'd6600, '0);                    // pending expire taken
		send_req(OP_EXPIRE, 64'd6700, '0);                   // ignored, expired
		send_req(OP_ACTIVATE, 64'd10000, '0);
		send_req(OP_ACTIVATE, 64'd10000, '0);                // re-arm while active
		send_req(OP_CHECK, 64'd11001, '0);                   // lifetime ran out
		drain();

		// zero lifetime: activate does nothing; longest phases
		set_config('0, PHASE_MAX, PHASE_MAX);
		send_req(OP_ACTIVATE, 64'd0, '0);
		send_req(OP_CHECK, 64'd0, '0);
		drain();

		// longest lifetime, off phase zero, huge skip to the top of time, past the lifetime
		set_config(LIFE_MAX, PHASE_MAX, '0);
		send_req(OP_ACTIVATE, 64'd0, '0);
		send_req(OP_CHECK, 64'(TIME_MAX), '0);
		send_req(OP_CHECK, 64'(TIME_MAX) - 1, '0);
		drain();

		// --- random phases
		for (int p = 0; p < PHASES; p++) begin
			run_phase(p);
		end

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/otl_pkg.sv
sv/otl_front.sv
sv/otl_queue.sv
sv/otl_back.sv
sv/on_off_toggler_with_lifetime_top.sv
verif/toggler_report_checker.sv
verif/on_off_toggler_with_lifetime_top_test.sv
